### rtl/core/bpc_pkg.sv
// Button press classifier package: field widths, codes, reset values and the
// result record shared by the classifier RTL. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    localparam int unsigned THR_W      = 10;   // hold threshold register width
    localparam int unsigned MODE_CNT_W = 4;    // mode_count register width
    localparam int unsigned MODE_W     = 3;    // display mode width
    localparam int unsigned BTN_W      = 2;    // edge_button width
    localparam int unsigned PIN_W      = 3;    // pin_levels width
    localparam int unsigned IN_DATA_W  = 8;    // edge_button + pin_levels, byte padded
    localparam int unsigned OUT_DATA_W = 8;    // result record, exactly one byte
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = THR_W;

    localparam logic [THR_W-1:0]      DUMP_RESET  = THR_W'(35);
    localparam logic [THR_W-1:0]      ERASE_RESET = THR_W'(65);
    localparam logic [MODE_CNT_W-1:0] MODE_RESET  = MODE_CNT_W'(3);

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DUMP_HOLD  = 2'd0,
        CFG_ERASE_HOLD = 2'd1,
        CFG_MODE_COUNT = 2'd2
    } t_cfg_idx;

    // item kind carried on tuser
    typedef enum logic {
        CMD_EDGE   = 1'b0,
        CMD_EXPIRE = 1'b1
    } t_cmd;

    // button numbers on edge_button; the fourth code names no button
    typedef enum logic [BTN_W-1:0] {
        BTN_MODE  = 2'd0,
        BTN_DUMP  = 2'd1,
        BTN_ERASE = 2'd2,
        BTN_NONE  = 2'd3
    } t_btn;

    // result record; last member lands in bit 0 of tdata
    typedef struct packed {
        logic              period_armed;
        logic [MODE_W-1:0] display_mode;
        logic              mode_changed;
        logic              long_press_two;
        logic              long_press_one;
        logic              short_press_one;
    } t_result;

endpackage : bpc_pkg

`default_nettype wire

### rtl/core/button_press_classifier.sv
// Button press classifier top level: debounce, hold counting and press
// classification for three active-low buttons. Depends on bpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Slave stream: one transfer per event. tuser = kind (0 falling edge,
//   1 debounce period expired); tdata = edge_button and sampled pin levels.
//   Master stream: exactly one result transfer per input transfer, in order,
//   carrying the press pulses, the display mode and the armed flag.
//   Config port: write enable, register index, data; written while idle.
// Timing
//   Each event is classified combinationally: state registers and the
//   result register load on the accepting edge, so the result is valid the
//   cycle after the transfer. One event per cycle is sustained while the
//   master is ready; the result register is the only stage in between.
// Stall
//   s_axis_tready is high while the result register is empty or being
//   drained this cycle; a stalled master holds the result and blocks new
//   events only while it stays stalled.
// Reset
//   Synchronous active-low reset clears pending flags, hold counts, mode and
//   armed flag, empties the result register and loads thresholds 35 / 65
//   and mode count 3.
module button_press_classifier #(
    parameter int unsigned COUNT_BITS = 10   // hold counter width, 4..16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // config write port
    input  wire logic                            i_cfg_we,
    input  wire logic [bpc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // event stream in
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    // [1:0] edge_button, [4:2] pin_levels, [7:5] zero
    input  wire logic [bpc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] cmd
    input  wire logic                            s_axis_tuser,
    // result stream out
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] short_press_one, [1] long_press_one, [2] long_press_two,
    // [3] mode_changed, [6:4] display_mode, [7] period_armed
    output      logic [bpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int unsigned CMP_W = (COUNT_BITS > bpc_pkg::THR_W) ?
                                    COUNT_BITS : bpc_pkg::THR_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // config registers
    logic [bpc_pkg::THR_W-1:0]      r_dump_thr;
    logic [bpc_pkg::THR_W-1:0]      r_erase_thr;
    logic [bpc_pkg::MODE_CNT_W-1:0] r_mode_count;

    // classifier state
    logic [2:0]                     r_pending, n_pending;
    logic [COUNT_BITS-1:0]          r_hold_one, n_hold_one;
    logic [COUNT_BITS-1:0]          r_hold_two, n_hold_two;
    logic [bpc_pkg::MODE_W-1:0]     r_mode, n_mode;
    logic                           r_armed, n_armed;

    // result register
    logic                           r_out_valid;
    bpc_pkg::t_result               r_result, n_result;

    // event decode
    bpc_pkg::t_cmd                  in_cmd;
    bpc_pkg::t_btn                  in_btn;
    logic [bpc_pkg::PIN_W-1:0]      in_pins;
    logic                           in_xfer;

    // expiry helpers
    logic [COUNT_BITS-1:0]          inc_one, inc_two;
    logic [bpc_pkg::MODE_CNT_W-1:0] mode_inc;
    logic                           rearm;

    assign in_cmd  = bpc_pkg::t_cmd'(s_axis_tuser);
    assign in_btn  = bpc_pkg::t_btn'(s_axis_tdata[bpc_pkg::BTN_W-1:0]);
    assign in_pins = s_axis_tdata[bpc_pkg::BTN_W +: bpc_pkg::PIN_W];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_result;

    // saturating hold counts, mode step with room for the wrap compare
    assign inc_one  = (r_hold_one == CNT_MAX) ? CNT_MAX : r_hold_one + 1'b1;
    assign inc_two  = (r_hold_two == CNT_MAX) ? CNT_MAX : r_hold_two + 1'b1;
    assign mode_inc = bpc_pkg::MODE_CNT_W'(r_mode) + 1'b1;

    always_comb begin
        n_pending = r_pending;
        n_hold_one = r_hold_one;
        n_hold_two = r_hold_two;
        n_mode = r_mode;
        n_armed = r_armed;
        rearm = 1'b0;
        n_result = '0;

        if (in_cmd == bpc_pkg::CMD_EDGE) begin
            // new press on an idle button arms (or re-arms) the period
            case (in_btn)
                bpc_pkg::BTN_MODE: begin
                    if (!r_pending[0]) begin
                        n_pending[0] = 1'b1;
                        n_armed = 1'b1;
                    end
                end
                bpc_pkg::BTN_DUMP: begin
                    if (!r_pending[1]) begin
                        n_pending[1] = 1'b1;
                        n_hold_one = '0;
                        n_armed = 1'b1;
                    end
                end
                bpc_pkg::BTN_ERASE: begin
                    if (!r_pending[2]) begin
                        n_pending[2] = 1'b1;
                        n_hold_two = '0;
                        n_armed = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_armed) begin
            n_armed = 1'b0;

            // button zero: confirm and step mode, wrap at mode_count or past 7
            if (r_pending[0]) begin
                if (!in_pins[0]) begin
                    if (mode_inc >= r_mode_count || mode_inc > 4'd7) begin
                        n_mode = '0;
                    end else begin
                        n_mode = mode_inc[bpc_pkg::MODE_W-1:0];
                    end
                    n_result.mode_changed = 1'b1;
                end
                n_pending[0] = 1'b0;
            end

            // button one: long at dump threshold, short on early release
            if (r_pending[1]) begin
                if (!in_pins[1]) begin
                    if (CMP_W'(inc_one) >= CMP_W'(r_dump_thr)) begin
                        n_result.long_press_one = 1'b1;
                        n_pending[1] = 1'b0;
                        n_hold_one = '0;
                    end else begin
                        n_hold_one = inc_one;
                        rearm = 1'b1;
                    end
                end else begin
                    n_result.short_press_one = 1'b1;
                    n_pending[1] = 1'b0;
                    n_hold_one = '0;
                end
            end

            // button two: long at erase threshold, early release is silent
            if (r_pending[2]) begin
                if (!in_pins[2]) begin
                    if (CMP_W'(inc_two) >= CMP_W'(r_erase_thr)) begin
                        n_result.long_press_two = 1'b1;
                        n_pending[2] = 1'b0;
                        n_hold_two = '0;
                    end else begin
                        n_hold_two = inc_two;
                        rearm = 1'b1;
                    end
                end else begin
                    n_pending[2] = 1'b0;
                    n_hold_two = '0;
                end
            end

            if (rearm) begin
                n_armed = 1'b1;
            end
        end

        n_result.display_mode = n_mode;
        n_result.period_armed = n_armed;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dump_thr <= bpc_pkg::DUMP_RESET;
            r_erase_thr <= bpc_pkg::ERASE_RESET;
            r_mode_count <= bpc_pkg::MODE_RESET;
        end else if (i_cfg_we) begin
            case (bpc_pkg::t_cfg_idx'(i_cfg_addr))
                bpc_pkg::CFG_DUMP_HOLD:  r_dump_thr <= i_cfg_wdata;
                bpc_pkg::CFG_ERASE_HOLD: r_erase_thr <= i_cfg_wdata;
                bpc_pkg::CFG_MODE_COUNT:
                    r_mode_count <= i_cfg_wdata[bpc_pkg::MODE_CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // classifier state, loads on each accepted event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_hold_one <= '0;
            r_hold_two <= '0;
            r_mode <= '0;
            r_armed <= 1'b0;
        end else if (in_xfer) begin
            r_pending <= n_pending;
            r_hold_one <= n_hold_one;
            r_hold_two <= n_hold_two;
            r_mode <= n_mode;
            r_armed <= n_armed;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= n_result;
        end
    end

    // any pending button keeps the debounce period running
    a_pending_armed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != 3'b000) |-> r_armed)
        else $error("button pending without an armed period");

    // button one is either short or long, never both
    a_one_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.short_press_one && r_result.long_press_one))
        else $error("button one flagged short and long together");

    // an accepted event always yields a result on the next cycle
    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("accepted event produced no result");

endmodule : button_press_classifier

`default_nettype wire

### tb/tb.sv
// Self-checking bench for button_press_classifier: directed table, then random
// press sequences under several idle patterns. Depends on bpc_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

    localparam int COUNT_BITS = 10;
    localparam int RAND_ITEMS = 186;     // per random phase, five phases
    localparam int HALF_CLK   = 6;

    // ---------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ---------------------------------------------------------------
    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_cfg_we       = 1'b0;
    logic [bpc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr     = bpc_pkg::CFG_DUMP_HOLD;
    logic [bpc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata    = '0;
    logic                            s_axis_tvalid  = 1'b0;
    logic                            s_axis_tready;
    // [1:0] edge_button, [4:2] pin_levels
    logic [bpc_pkg::IN_DATA_W-1:0]   s_axis_tdata   = '0;
    logic                            s_axis_tuser   = 1'b0; // [0] cmd
    logic                            m_axis_tvalid;
    logic                            m_axis_tready  = 1'b0;
    // [0] short_press_one, [1] long_press_one, [2] long_press_two,
    // [3] mode_changed, [6:4] display_mode, [7] period_armed
    logic [bpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata;

    button_press_classifier #(
        .COUNT_BITS(COUNT_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(HALF_CLK) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Classifier shadow: registers and state as the block should hold them
    // ---------------------------------------------------------------
    logic [bpc_pkg::THR_W-1:0]      dump_limit  = bpc_pkg::DUMP_RESET;
    logic [bpc_pkg::THR_W-1:0]      erase_limit = bpc_pkg::ERASE_RESET;
    logic [bpc_pkg::MODE_CNT_W-1:0] mode_limit  = bpc_pkg::MODE_RESET;

    logic [bpc_pkg::PIN_W-1:0]      btn_pending = '0;
    logic [COUNT_BITS-1:0]          hold_one    = '0;
    logic [COUNT_BITS-1:0]          hold_two    = '0;
    logic [bpc_pkg::MODE_W-1:0]     shown_mode  = '0;
    logic                           armed       = 1'b0;

    // results still owed by the block, oldest first
    bpc_pkg::t_result press_reports[$];

    int mismatches     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // physical buttons behind the random stimulus: down flag, expiries left
    logic [bpc_pkg::PIN_W-1:0] key_down = '0;
    int                        hold_left [bpc_pkg::PIN_W];

    // Applies one event to the shadow state and returns the result record.
    function automatic bpc_pkg::t_result classify_event(input bpc_pkg::t_cmd cmd,
                                                        input bpc_pkg::t_btn btn,
                                                        input logic [bpc_pkg::PIN_W-1:0] pins);
        bpc_pkg::t_result               res;
        logic                           rearm;
        logic [bpc_pkg::MODE_CNT_W-1:0] next_mode;
        res   = '0;
        rearm = 1'b0;
        if (cmd == bpc_pkg::CMD_EDGE) begin
            // a repeat edge on a pending button must not restart the period
            if (btn != bpc_pkg::BTN_NONE && !btn_pending[btn]) begin
                btn_pending[btn] = 1'b1;
                if (btn == bpc_pkg::BTN_DUMP)
                    hold_one = '0;
                else if (btn == bpc_pkg::BTN_ERASE)
                    hold_two = '0;
                armed = 1'b1;
            end
        end else if (armed) begin
            armed = 1'b0;
            if (btn_pending[bpc_pkg::BTN_MODE]) begin
                if (!pins[bpc_pkg::BTN_MODE]) begin
                    // wrap at mode_limit or when the 3-bit mode overflows
                    next_mode = bpc_pkg::MODE_CNT_W'(shown_mode) + 1'b1;
                    if (next_mode >= mode_limit ||
                        next_mode > bpc_pkg::MODE_CNT_W'((1 << bpc_pkg::MODE_W) - 1))
                        next_mode = '0;
                    shown_mode       = next_mode[bpc_pkg::MODE_W-1:0];
                    res.mode_changed = 1'b1;
                end
                btn_pending[bpc_pkg::BTN_MODE] = 1'b0;
            end
            if (btn_pending[bpc_pkg::BTN_DUMP]) begin
                if (!pins[bpc_pkg::BTN_DUMP]) begin
                    hold_one = (hold_one == '1) ? hold_one : hold_one + 1'b1;
                    if (COUNT_BITS'(hold_one) >= dump_limit) begin
                        res.long_press_one             = 1'b1;
                        btn_pending[bpc_pkg::BTN_DUMP] = 1'b0;
                        hold_one                       = '0;
                    end else begin
                        rearm = 1'b1;
                    end
                end else begin
                    res.short_press_one            = 1'b1;
                    btn_pending[bpc_pkg::BTN_DUMP] = 1'b0;
                    hold_one                       = '0;
                end
            end
            if (btn_pending[bpc_pkg::BTN_ERASE]) begin
                if (!pins[bpc_pkg::BTN_ERASE]) begin
                    hold_two = (hold_two == '1) ? hold_two : hold_two + 1'b1;
                    if (COUNT_BITS'(hold_two) >= erase_limit) begin
                        res.long_press_two              = 1'b1;
                        btn_pending[bpc_pkg::BTN_ERASE] = 1'b0;
                        hold_two                        = '0;
                    end else begin
                        rearm = 1'b1;
                    end
                end else begin
                    // early release of the erase button is silent
                    btn_pending[bpc_pkg::BTN_ERASE] = 1'b0;
                    hold_two                        = '0;
                end
            end
            if (rearm)
                armed = 1'b1;
        end
        res.display_mode = shown_mode;
        res.period_armed = armed;
        return res;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("tb: mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            note_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // ---------------------------------------------------------------
    // Event side: optional idle gap, present the event, hold until transfer.
    // The expectation is queued at the accepting edge.
    // ---------------------------------------------------------------
    task automatic send_event(input bpc_pkg::t_cmd cmd, input bpc_pkg::t_btn btn,
                              input logic [bpc_pkg::PIN_W-1:0] pins,
                              input bit typed, input bpc_pkg::t_result want);
        bpc_pkg::t_result predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= bpc_pkg::IN_DATA_W'({pins, btn});
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predicted = classify_event(cmd, btn, pins);
        press_reports.push_back(typed ? want : predicted);
    endtask

    // Stop sending and wait until every owed result has arrived.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (press_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Back-to-back writes of all three registers; block must be idle.
    task automatic write_limits(input int dump, input int erase, input int modes);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= bpc_pkg::CFG_DUMP_HOLD;
        i_cfg_wdata <= bpc_pkg::CFG_DATA_W'(dump);
        @(posedge i_clk);
        dump_limit   = bpc_pkg::THR_W'(dump);
        i_cfg_addr  <= bpc_pkg::CFG_ERASE_HOLD;
        i_cfg_wdata <= bpc_pkg::CFG_DATA_W'(erase);
        @(posedge i_clk);
        erase_limit  = bpc_pkg::THR_W'(erase);
        i_cfg_addr  <= bpc_pkg::CFG_MODE_COUNT;
        i_cfg_wdata <= bpc_pkg::CFG_DATA_W'(modes);
        @(posedge i_clk);
        mode_limit   = bpc_pkg::MODE_CNT_W'(modes);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly real presses: an edge when a key goes down, expiries while it
    // is held, release after a random number of periods. Some pure noise.
    task automatic random_event();
        bpc_pkg::t_cmd             cmd;
        bpc_pkg::t_btn             btn;
        logic [bpc_pkg::PIN_W-1:0] pins;
        int                        roll;
        int                        span;
        roll = $urandom_range(99);
        pins = ~key_down;
        if (roll < 10) begin
            cmd  = bpc_pkg::t_cmd'($urandom_range(1));
            btn  = bpc_pkg::t_btn'($urandom_range(3));
            pins = bpc_pkg::PIN_W'($urandom_range(7));
        end else if (roll < 42) begin
            cmd = bpc_pkg::CMD_EDGE;
            btn = ($urandom_range(9) == 0) ? bpc_pkg::BTN_NONE :
                                             bpc_pkg::t_btn'($urandom_range(2));
            if (btn != bpc_pkg::BTN_NONE && !key_down[btn]) begin
                case (btn)
                    bpc_pkg::BTN_DUMP:  span = (dump_limit > 40) ? 40 : int'(dump_limit);
                    bpc_pkg::BTN_ERASE: span = (erase_limit > 40) ? 40 : int'(erase_limit);
                    default:            span = 0;
                endcase
                key_down[btn]  = 1'b1;
                hold_left[btn] = $urandom_range(span + 2);
                pins           = ~key_down;
            end
        end else begin
            cmd = bpc_pkg::CMD_EXPIRE;
            btn = bpc_pkg::t_btn'($urandom_range(3));   // ignored on expiry, still varied
            for (int b = 0; b < bpc_pkg::PIN_W; b++) begin
                if (key_down[b]) begin
                    if (hold_left[b] == 0)
                        key_down[b] = 1'b0;
                    else
                        hold_left[b]--;
                end
            end
        end
        // occasional contact bounce on one pin
        if ($urandom_range(24) == 0)
            pins[$urandom_range(bpc_pkg::PIN_W - 1)] ^= 1'b1;
        send_event(cmd, btn, pins, 1'b0, '0);
    endtask

    // ---------------------------------------------------------------
    // Result side: random stall, compare each transfer with the oldest
    // expectation field by field
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : result_side
        bpc_pkg::t_result got;
        bpc_pkg::t_result want;
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = bpc_pkg::t_result'(m_axis_tdata);
            if (press_reports.size() == 0) begin
                note_mismatch($sformatf("unexpected result 0x%02h", m_axis_tdata));
            end else begin
                want = press_reports.pop_front();
                check_field("short_press_one", got.short_press_one, want.short_press_one);
                check_field("long_press_one",  got.long_press_one,  want.long_press_one);
                check_field("long_press_two",  got.long_press_two,  want.long_press_two);
                check_field("mode_changed",    got.mode_changed,    want.mode_changed);
                check_field("display_mode",    got.display_mode,    want.display_mode);
                check_field("period_armed",    got.period_armed,    want.period_armed);
            end
        end
    end

    // ---------------------------------------------------------------
    // Directed table, run with reset limits (35 / 65 / 3).
    // Expected record is typed in only where it is obvious; packed as
    // {armed, mode[2:0], mode_changed, long2, long1, short1}.
    // ---------------------------------------------------------------
    typedef struct {
        bpc_pkg::t_cmd             cmd;
        bpc_pkg::t_btn             btn;
        logic [bpc_pkg::PIN_W-1:0] pins;
        bit                        typed;
        bpc_pkg::t_result          want;
    } t_stim_row;

    t_stim_row dir_rows [25] = '{
        '{bpc_pkg::CMD_EXPIRE, bpc_pkg::BTN_MODE,  3'b111, 1'b1, 8'h00},  // expiry while idle
        '{bpc_pkg::CMD_EDGE,   bpc_pkg::BTN_NONE,  3'b000, 1'b1, 8'h00},  // edge naming no button
        '{bpc_pkg::CMD_EDGE,   bpc_pkg::BTN_MODE,  3'b110, 1'b1, 8'h80},  // arms the period
        '{bpc_pkg::CMD_EDGE,   bpc_pkg::BTN_MODE,  3'b110, 1'b0, 8'h00},  // repeat edge, ignored
        '{bpc_pkg::CMD_EXPIRE, bpc_pkg::BTN_NONE,  3'b110, 1'b1, 8'h18},  // mode 0 -> 1
        '{bpc_pkg::CMD_EDGE,   bpc_pkg::BTN_MODE,  3'b110, 1'b0, 8'h00},
        '{bpc_pkg::CMD_EXPIRE, bpc_pkg::BTN_MODE,  3'b110, 1'b0, 8'h00},  // mode 2
        '{bpc_pkg::CMD_EDGE,   bpc_pkg::BTN_MODE,  3'b110, 1'b0, 8'h00},
        '{bpc_pkg::CMD_EXPIRE, bpc_pkg::BTN_DUMP,  3'b110, 1'b0, 8'h00},  // wraps to 0
        '{bpc_pkg::CMD_EDGE,   bpc_pkg::BTN_MODE,  3'b111, 1'b0, 8'h00},
        '{bpc_pkg::CMD_EXPIRE, bpc_pkg::BTN_ERASE, 3'b111, 1'b0, 8'h00},  // released: no step
        '{bpc_pkg::CMD_EDGE,   bpc_pkg::BTN_DUMP,  3'b101, 1'b0, 8'h00},
        '{bpc_pkg::CMD_EXPIRE, bpc_pkg::BTN_MODE,  3'b101, 1'b0, 8'h00},  // held, rearm
        '{bpc_pkg::CMD_EXPIRE, bpc_pkg::BTN_MODE,  3'b111, 1'b0, 8'h00},  // short press
        '{bpc_pkg::CMD_EDGE,   bpc_pkg::BTN_ERASE, 3'b011, 1'b0, 8'h00},
        '{bpc_pkg::CMD_EXPIRE, bpc_pkg::BTN_MODE,  3'b011, 1'b0, 8'h00},
        '{bpc_pkg::CMD_EXPIRE, bpc_pkg::BTN_MODE,  3'b111, 1'b0, 8'h00},  // silent erase release
        '{bpc_pkg::CMD_EDGE,   bpc_pkg::BTN_DUMP,  3'b000, 1'b0, 8'h00},
        '{bpc_pkg::CMD_EDGE,   bpc_pkg::BTN_ERASE, 3'b000, 1'b0, 8'h00},
        '{bpc_pkg::CMD_EDGE,   bpc_pkg::BTN_MODE,  3'b000, 1'b0, 8'h00},
        '{bpc_pkg::CMD_EDGE,   bpc_pkg::BTN_DUMP,  3'b000, 1'b0, 8'h00},  // pending, ignored
        '{bpc_pkg::CMD_EXPIRE, bpc_pkg::BTN_NONE,  3'b000, 1'b0, 8'h00},  // all three at once
        '{bpc_pkg::CMD_EXPIRE, bpc_pkg::BTN_NONE,  3'b000, 1'b0, 8'h00},
        '{bpc_pkg::CMD_EXPIRE, bpc_pkg::BTN_NONE,  3'b111, 1'b0, 8'h00},
        '{bpc_pkg::CMD_EXPIRE, bpc_pkg::BTN_NONE,  3'b111, 1'b0, 8'h00}   // no longer armed
    };

    // per random phase: limits and idle pattern (sender %, receiver %)
    int ph_dump  [5] = '{1,    0,  1023, 20,  9};
    int ph_erase [5] = '{1023, 0,  7,    33,  1};
    int ph_modes [5] = '{8,    1,  0,    5,   15};
    int ph_send  [5] = '{0,    80, 0,    22,  0};
    int ph_recv  [5] = '{0,    0,  80,   22,  0};

    initial begin : stimulus
        foreach (hold_left[b])
            hold_left[b] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            send_event(dir_rows[r].cmd, dir_rows[r].btn, dir_rows[r].pins,
                       dir_rows[r].typed, dir_rows[r].want);

        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            send_idle_pct  = ph_send[ph];
            recv_stall_pct = ph_recv[ph];
            write_limits(ph_dump[ph], ph_erase[ph], ph_modes[ph]);
            for (int k = 0; k < RAND_ITEMS; k++) begin
                // sender holds off mid-phase until the block has caught up
                if (k == RAND_ITEMS / 2)
                    wait_drained();
                random_event();
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && press_reports.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
